### sv/gacu_pkg.sv
// Shared types, constants and the arctangent step table for the gaze angle block.
`default_nettype none
package gacu_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int AtanEntries        = 24;

   localparam int PointWidth = 16;
   localparam int OffWidth   = 17;
   localparam int VecWidth   = 27;
   localparam int AccWidth   = 29;
   localparam int VecShift   = 8;
   localparam int OutShift   = 14;
   localparam int AngleWidth = 15;
   localparam int RoundWidth = 28;

   localparam logic signed [OffWidth-1:0]  CentreQ14  = 17'sd8192;
   localparam logic signed [AccWidth-1:0]  Deg90Acc   = 29'sd94371840;
   localparam logic signed [AccWidth-1:0]  Deg180Acc  = 29'sd188743680;
   localparam logic [RoundWidth-1:0]       RoundHalf  = 28'd8192;
   localparam logic [AngleWidth-1:0]       FullTurn   = 15'd23040;

   typedef struct packed {
      logic signed [VecWidth-1:0] u;
      logic signed [VecWidth-1:0] v;
      logic signed [AccWidth-1:0] acc;
      logic                       mirror;
      logic                       centre;
   } gacu_vec_type;

   // atan(2^-i) in degrees, 20 fractional bits, rounded to nearest
   function automatic logic signed [AccWidth-1:0] atan_step(input logic [4:0] idx);
      logic signed [AccWidth-1:0] r;
      case (idx)
         5'd0:    r = 29'sd47185920;
         5'd1:    r = 29'sd27855475;
         5'd2:    r = 29'sd14718068;
         5'd3:    r = 29'sd7471121;
         5'd4:    r = 29'sd3750058;
         5'd5:    r = 29'sd1876857;
         5'd6:    r = 29'sd938658;
         5'd7:    r = 29'sd469357;
         5'd8:    r = 29'sd234682;
         5'd9:    r = 29'sd117342;
         5'd10:   r = 29'sd58671;
         5'd11:   r = 29'sd29335;
         5'd12:   r = 29'sd14668;
         5'd13:   r = 29'sd7334;
         5'd14:   r = 29'sd3667;
         5'd15:   r = 29'sd1833;
         5'd16:   r = 29'sd917;
         5'd17:   r = 29'sd458;
         5'd18:   r = 29'sd229;
         5'd19:   r = 29'sd115;
         5'd20:   r = 29'sd57;
         5'd21:   r = 29'sd29;
         5'd22:   r = 29'sd14;
         5'd23:   r = 29'sd7;
         default: r = 29'sd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### sv/gacu_front.sv
// Input skid buffer and first stage: centre offset, folding and quadrant pre-rotation.
`default_nettype none
module gacu_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        enable,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [31:0]                 req_tdata,
   output gacu_pkg::gacu_vec_type           out_data,
   output logic                             out_valid
);

   localparam int PW = gacu_pkg::PointWidth;
   localparam int OW = gacu_pkg::OffWidth;
   localparam int VW = gacu_pkg::VecWidth;

   logic                   skid_valid_ff, skid_valid_in;
   logic [2*PW-1:0]        skid_data_ff;
   logic                   accept;
   logic                   src_valid;
   logic [2*PW-1:0]        src_data;
   logic signed [OW-1:0]   dx, dy;
   logic signed [VW-1:0]   dx_w, dy_w, u0, v0;
   gacu_pkg::gacu_vec_type stage_in, stage_ff;
   logic                   valid_ff;

   assign req_tready = ~skid_valid_ff;
   assign accept     = req_tvalid & ~skid_valid_ff;
   assign src_valid  = skid_valid_ff | accept;
   assign src_data   = skid_valid_ff ? skid_data_ff : req_tdata;

   // holds one transfer taken while the pipeline is stalled
   always_comb begin
      skid_valid_in = skid_valid_ff;
      if (enable) begin
         skid_valid_in = 1'b0;
      end else if (accept) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
      if (accept & ~enable) begin
         skid_data_ff <= req_tdata;
      end
   end

   always_comb begin
      dx   = $signed({src_data[PW-1], src_data[PW-1:0]}) - gacu_pkg::CentreQ14;
      dy   = $signed({src_data[2*PW-1], src_data[2*PW-1:PW]}) - gacu_pkg::CentreQ14;
      dx_w = {{(VW-OW){dx[OW-1]}}, dx};
      dy_w = {{(VW-OW){dy[OW-1]}}, dy};
      u0   = (-dy_w) <<< gacu_pkg::VecShift;
      v0   = (dx[OW-1] ? -dx_w : dx_w) <<< gacu_pkg::VecShift;
      stage_in.mirror = dx[OW-1];
      stage_in.centre = (dx == '0) && (dy == '0);
      if (u0[VW-1]) begin
         // lower half: turn by -90 degrees first
         stage_in.u   = v0;
         stage_in.v   = -u0;
         stage_in.acc = gacu_pkg::Deg90Acc;
      end else begin
         stage_in.u   = u0;
         stage_in.v   = v0;
         stage_in.acc = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= src_valid;
      end
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign out_data  = stage_ff;
   assign out_valid = valid_ff;

endmodule
`default_nettype wire

### sv/gacu_cordic_stage.sv
// One registered CORDIC vectoring iteration with a fixed shift.
`default_nettype none
module gacu_cordic_stage #(
   parameter int Index = 0
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    enable,
   input  wire gacu_pkg::gacu_vec_type  in_data,
   input  wire logic                    in_valid,
   output gacu_pkg::gacu_vec_type       out_data,
   output logic                         out_valid
);

   localparam int VW = gacu_pkg::VecWidth;
   localparam int AW = gacu_pkg::AccWidth;
   localparam logic signed [AW-1:0] AtanStep = gacu_pkg::atan_step(5'(Index));

   logic signed [VW-1:0]   u, v, us, vs;
   logic signed [AW-1:0]   acc;
   gacu_pkg::gacu_vec_type data_in, data_ff;
   logic                   valid_ff;

   always_comb begin
      u   = in_data.u;
      v   = in_data.v;
      acc = in_data.acc;
      us  = u >>> Index;
      vs  = v >>> Index;
      data_in = in_data;
      if (!v[VW-1]) begin
         data_in.u   = u + vs;
         data_in.v   = v - us;
         data_in.acc = acc + AtanStep;
      end else begin
         data_in.u   = u - vs;
         data_in.v   = v + us;
         data_in.acc = acc - AtanStep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_data  = data_ff;
   assign out_valid = valid_ff;

endmodule
`default_nettype wire

### sv/gacu_back.sv
// Last stage: clamp, round to 1/64 degree, mirror to the left half, output register.
`default_nettype none
module gacu_back (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 enable,
   input  wire gacu_pkg::gacu_vec_type               in_data,
   input  wire logic                                 in_valid,
   output logic                                      rsp_tvalid,
   output logic [gacu_pkg::AngleWidth-1:0]           angle_deg,
   output logic                                      at_centre
);

   localparam int AW = gacu_pkg::AccWidth;
   localparam int RW = gacu_pkg::RoundWidth;
   localparam int NW = gacu_pkg::AngleWidth;

   logic [RW-1:0] clamped, rounded;
   logic [NW-1:0] r, angle_in, angle_ff;
   logic          valid_ff, centre_ff;

   always_comb begin
      if (in_data.acc[AW-1]) begin
         clamped = '0;
      end else if (in_data.acc > gacu_pkg::Deg180Acc) begin
         clamped = gacu_pkg::Deg180Acc[RW-1:0];
      end else begin
         clamped = in_data.acc[RW-1:0];
      end
      rounded = clamped + gacu_pkg::RoundHalf;
      r       = {1'b0, rounded[RW-1:gacu_pkg::OutShift]};
      if (in_data.centre) begin
         angle_in = '0;
      end else if (in_data.mirror && (r != '0)) begin
         angle_in = gacu_pkg::FullTurn - r;
      end else if (in_data.mirror) begin
         angle_in = '0; // a full turn wraps to zero
      end else begin
         angle_in = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         angle_ff  <= angle_in;
         centre_ff <= in_data.centre;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign angle_deg  = angle_ff;
   assign at_centre  = centre_ff;

endmodule
`default_nettype wire

### sv/gaze_angle_clockwise_from_up.sv
// Gaze angle clockwise from up: CORDIC vectoring pipeline, top level.
//
// Input channel req_*: one gaze point per transfer, x and y in signed Q2.14.
// Result channel rsp_*: one result per point, in order: angle in degrees with
// six fractional bits (0 up to just under 360), and a flag in tuser when the
// point sits exactly on the centre (0.5, 0.5), in which case the angle is 0.
// The datapath is a front stage, one register stage per CORDIC iteration and
// a rounding stage that is also the output register. Above 24 steps only 24
// iterations are built. One point is taken every cycle while the receiver
// keeps up.
// The whole pipeline advances together; when rsp_tready is low with a result
// waiting, all stages hold and a single input skid register still takes one
// more transfer, so req_tready depends only on that register.
// Reset empties the pipeline and the skid register; no result is lost or
// repeated across a stall.
`default_nettype none
module gaze_angle_clockwise_from_up #(
   parameter int CORDIC_STEPS = gacu_pkg::CordicStepsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [15:0] point_x, [31:16] point_y
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [14:0] angle_deg, [15] zero
   output logic [0:0]       rsp_tuser    // [0] at_centre
);

   localparam int NumIter = (CORDIC_STEPS < gacu_pkg::AtanEntries) ?
                            CORDIC_STEPS : gacu_pkg::AtanEntries;

   gacu_pkg::gacu_vec_type             pipe_data  [0:NumIter];
   logic                               pipe_valid [0:NumIter];
   logic                               enable;
   logic [gacu_pkg::AngleWidth-1:0]    angle_deg;
   logic                               at_centre;

   assign enable = rsp_tready | ~rsp_tvalid;

   gacu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .out_data   (pipe_data[0]),
      .out_valid  (pipe_valid[0])
   );

   for (genvar k = 0; k < NumIter; k++) begin : g_iter
      gacu_cordic_stage #(
         .Index (k)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_data   (pipe_data[k]),
         .in_valid  (pipe_valid[k]),
         .out_data  (pipe_data[k+1]),
         .out_valid (pipe_valid[k+1])
      );
   end

   gacu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .in_data    (pipe_data[NumIter]),
      .in_valid   (pipe_valid[NumIter]),
      .rsp_tvalid (rsp_tvalid),
      .angle_deg  (angle_deg),
      .at_centre  (at_centre)
   );

   assign rsp_tdata = {1'b0, angle_deg};
   assign rsp_tuser = at_centre;

endmodule
`default_nettype wire

### dv/tb_top.sv
// Self-checking bench for the gaze angle block: random and directed points, in-order checking.
`default_nettype none
module tb_top;

   localparam int CordicSteps  = gacu_pkg::CordicStepsDefault;
   localparam int RandomPoints = 1625;
   localparam int QuietFrom    = 700;    // sender and receiver never idle in this window
   localparam int QuietTo      = 1000;
   localparam int DrainEarly   = 25;     // sender waits for an empty pipeline here
   localparam int DrainLate    = 1200;
   localparam int IdlePct      = 32;
   localparam int StallLimit   = 4000;
   localparam int ReportMax    = 10;

   typedef struct packed {
      logic signed [gacu_pkg::PointWidth-1:0] y;
      logic signed [gacu_pkg::PointWidth-1:0] x;
   } gaze_point_type;

   typedef struct packed {
      logic [gacu_pkg::AngleWidth-1:0] angle;
      logic                            centre;
   } gaze_result_type;

   // atan(2^-i) in degrees, 20 fractional bits
   localparam longint AtanDegQ20 [gacu_pkg::AtanEntries] = '{
      47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
      938658, 469357, 234682, 117342, 58671, 29335,
      14668, 7334, 3667, 1833, 917, 458,
      229, 115, 57, 29, 14, 7
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [15:0] point_x, [31:16] point_y
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [14:0] angle_deg, [15] zero
   logic [0:0]  rsp_tuser;        // [0] at_centre

   gaze_point_type  point_q[$];
   gaze_result_type angle_due_q[$];
   int              points_sent = 0;
   int              drained_at = -1;
   int              mismatches = 0;
   int              quiet_cycles = 0;

   gaze_angle_clockwise_from_up #(.CORDIC_STEPS(CordicSteps)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 0;
   end

   // Clockwise angle from up, CORDIC vectoring on the offset from the centre.
   function automatic gaze_result_type gaze_angle_of(input gaze_point_type p);
      gaze_result_type res;
      longint dx, dy, u, v, us, vs, t, acc, r;
      int n;
      dx = longint'(p.x) - 8192;
      dy = longint'(p.y) - 8192;
      res = '0;
      if (dx == 0 && dy == 0) begin
         res.centre = 1'b1;
         return res;
      end
      u = -dy * 256;
      v = (dx < 0 ? -dx : dx) * 256;
      acc = 0;
      if (u < 0) begin
         // lower half: turn by -90 first
         t = u;
         u = v;
         v = -t;
         acc = longint'(90) << 20;
      end
      n = (CordicSteps < gacu_pkg::AtanEntries) ? CordicSteps : gacu_pkg::AtanEntries;
      for (int i = 0; i < n; i++) begin
         us = u >>> i;
         vs = v >>> i;
         if (v >= 0) begin
            u = u + vs;
            v = v - us;
            acc = acc + AtanDegQ20[i];
         end else begin
            u = u - vs;
            v = v + us;
            acc = acc - AtanDegQ20[i];
         end
      end
      if (acc < 0) acc = 0;
      if (acc > (longint'(180) << 20)) acc = longint'(180) << 20;
      r = (acc + 8192) >>> 14;
      if (dx < 0) r = 23040 - r;
      if (r >= 23040) r = 0;
      res.angle = r[gacu_pkg::AngleWidth-1:0];
      return res;
   endfunction

   function automatic bit idle_now();
      if (points_sent >= QuietFrom && points_sent < QuietTo)
         return 1'b0;
      return $urandom_range(99) < IdlePct;
   endfunction

   function automatic gaze_point_type make_point(input int px, input int py);
      gaze_point_type p;
      p.x = px[15:0];
      p.y = py[15:0];
      return p;
   endfunction

   // sender
   always @(posedge clock) begin
      gaze_point_type p;
      bit hold;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         hold = 1'b0;
         if ((points_sent == DrainEarly || points_sent == DrainLate) &&
             drained_at != points_sent) begin
            if (req_tvalid || angle_due_q.size() != 0)
               hold = 1'b1;
            else
               drained_at = points_sent;
         end
         if (!hold && point_q.size() != 0 && !idle_now()) begin
            p = point_q.pop_front();
            req_tdata   <= p;
            req_tvalid  <= 1'b1;
            points_sent <= points_sent + 1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !idle_now();
   end

   // input transfers feed the predictor
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         angle_due_q.push_back(gaze_angle_of(gaze_point_type'(req_tdata)));
   end

   // result transfers against the oldest prediction
   always @(posedge clock) begin
      gaze_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (angle_due_q.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= ReportMax)
               $display("unexpected result: angle %0d centre %0d",
                        rsp_tdata[14:0], rsp_tuser[0]);
         end else begin
            want = angle_due_q.pop_front();
            if (rsp_tdata != {1'b0, want.angle} || rsp_tuser[0] !== want.centre) begin
               mismatches = mismatches + 1;
               if (mismatches <= ReportMax)
                  $display("result mismatch: angle exp %0d got %0d, centre exp %0d got %0d",
                           want.angle, rsp_tdata, want.centre, rsp_tuser[0]);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("gaze_angle_clockwise_from_up: mismatch");
         $finish;
      end
   end

   initial begin
      int kind, ox, oy;
      // directed: centre, corners, axes, wrap at 360, clamp on straight down
      point_q.push_back(make_point(8192, 8192));
      point_q.push_back(make_point(-32768, -32768));
      point_q.push_back(make_point(32767, 32767));
      point_q.push_back(make_point(-32768, 32767));
      point_q.push_back(make_point(32767, -32768));
      point_q.push_back(make_point(8192, 0));
      point_q.push_back(make_point(8192, -32768));
      point_q.push_back(make_point(8192, 16384));
      point_q.push_back(make_point(8192, 32767));
      point_q.push_back(make_point(16384, 8192));
      point_q.push_back(make_point(0, 8192));
      point_q.push_back(make_point(32767, 8192));
      point_q.push_back(make_point(-32768, 8192));
      point_q.push_back(make_point(8191, -32768));
      point_q.push_back(make_point(8193, -32768));
      point_q.push_back(make_point(8191, 0));
      point_q.push_back(make_point(8193, 8192));
      point_q.push_back(make_point(8191, 8192));
      point_q.push_back(make_point(8192, 8191));
      point_q.push_back(make_point(8192, 8193));
      point_q.push_back(make_point(8191, 32767));
      point_q.push_back(make_point(12288, 4096));
      point_q.push_back(make_point(4096, 12288));
      point_q.push_back(make_point(12288, 12288));
      point_q.push_back(make_point(4096, 4096));
      for (int n = 0; n < RandomPoints; n++) begin
         kind = $urandom_range(9);
         case (kind)
            0, 1, 2, 3: begin
               ox = $urandom;
               oy = $urandom;
               point_q.push_back(make_point(ox, oy));
            end
            4, 5: begin
               // close to the centre, tiny offsets
               ox = 8192 + $urandom_range(16) - 8;
               oy = 8192 + $urandom_range(16) - 8;
               point_q.push_back(make_point(ox, oy));
            end
            6: begin
               oy = $urandom;
               point_q.push_back(make_point(8192 + $urandom_range(2) - 1, oy));
            end
            7: begin
               ox = $urandom;
               point_q.push_back(make_point(ox, 8192 + $urandom_range(2) - 1));
            end
            default: begin
               // normal gaze range 0..1
               ox = $urandom_range(16384);
               oy = $urandom_range(16384);
               point_q.push_back(make_point(ox, oy));
            end
         endcase
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (point_q.size() != 0 || req_tvalid || angle_due_q.size() != 0)
         @(posedge clock);
      repeat (CordicSteps + 8) @(posedge clock);

      if (mismatches == 0 && angle_due_q.size() == 0)
         $display("gaze_angle_clockwise_from_up: match");
      else
         $display("gaze_angle_clockwise_from_up: mismatch");
      $finish;
   end

endmodule
`default_nettype wire
